// ===== hw/rtl/srle_pkg.sv =====
// Shared types and constants for the 8-bit RLE scanline decoder.
// Used by srle_ctrl, srle_dpath and sgi_rle8_row_decoder; no dependencies.
package srle_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int LANES     = 4;
    // Lanes per group are capped at the four output lanes.
    localparam int GROUP     = (LANES > 4) ? 4 : ((LANES < 1) ? 1 : LANES);

    localparam int WIDTH_W   = 13;
    localparam int PL_W      = $clog2(MAX_WIDTH + 1);
    localparam int BC_W      = 15;
    localparam logic [BC_W-1:0] BYTE_SAT = {BC_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RS_BUSY    = 2'd0,
        RS_DONE    = 2'd1,
        RS_SHORT   = 2'd2,
        RS_OVERRUN = 2'd3
    } t_status;

    typedef enum logic {
        CS_TAKE   = 1'b0,
        CS_REPEAT = 1'b1
    } t_ctl_state;

    typedef struct packed {
        logic take_byte;
        logic emit_group;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic phase_repeat;
        logic group_last;
    } t_stat;

    typedef struct packed {
        logic [BC_W-1:0] row_bytes;
        t_status         status;
        logic            row_end;
        logic [2:0]      count;
        logic [3:0][7:0] pixel;
    } t_result;

endpackage

// ===== hw/rtl/srle_ctrl.sv =====
// Controller FSM: byte intake and repeat-run group sequencing.
// Depends on srle_pkg; drives srle_dpath through t_cmd, reads t_stat.
module srle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srle_pkg::t_stat i_stat,
    output srle_pkg::t_cmd  o_cmd
);

    srle_pkg::t_ctl_state r_state;
    srle_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srle_pkg::CS_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            srle_pkg::CS_TAKE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_stat.phase_repeat) begin
                        n_state = srle_pkg::CS_REPEAT;
                    end
                end
            end
            srle_pkg::CS_REPEAT: begin
                // one lane group per cycle while the output slot is free
                if (i_stat.out_free) begin
                    o_cmd.emit_group = 1'b1;
                    if (i_stat.group_last) begin
                        n_state = srle_pkg::CS_TAKE;
                    end
                end
            end
            default: begin
                n_state = srle_pkg::CS_TAKE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srle_dpath.sv =====
// Datapath: row state, run counters, width register and output register.
// Depends on srle_pkg; commanded by srle_ctrl.
module srle_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [srle_pkg::WIDTH_W-1:0]  i_cfg_wr_data,
    input  logic [7:0]                    i_byte,
    input  logic                          i_out_ready,
    input  srle_pkg::t_cmd                i_cmd,
    output srle_pkg::t_stat               o_stat,
    output srle_pkg::t_result             o_result,
    output logic                          o_out_valid
);

    logic [srle_pkg::WIDTH_W-1:0] r_row_width;
    srle_pkg::t_phase             r_phase, n_phase;
    logic [6:0]                   r_run, n_run;
    logic [srle_pkg::PL_W-1:0]    r_pl, n_pl;
    logic [srle_pkg::BC_W-1:0]    r_bc, n_bc;
    logic                         r_ovr, n_ovr;
    logic [7:0]                   r_rep_val, n_rep_val;
    srle_pkg::t_result            r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic                         out_free;
    logic [srle_pkg::PL_W-1:0]    eff_w;
    logic [srle_pkg::PL_W-1:0]    pl_base;
    logic                         ovr_base;
    logic [srle_pkg::BC_W-1:0]    bc_inc;
    logic [2:0]                   grp_n;
    logic [6:0]                   rem_run;
    logic [srle_pkg::PL_W-1:0]    rem_pl;
    logic                         grp_last;

    assign out_free = !r_out_valid || i_out_ready;

    // effective width: zero acts as one, clamp at the maximum
    always_comb begin
        if (r_row_width == '0) begin
            eff_w = srle_pkg::PL_W'(1);
        end else if (32'(r_row_width) > srle_pkg::MAX_WIDTH) begin
            eff_w = srle_pkg::PL_W'(srle_pkg::MAX_WIDTH);
        end else begin
            eff_w = srle_pkg::PL_W'(r_row_width);
        end
    end

    // first byte of a row reloads the width and clears the overrun flag
    assign pl_base  = (r_bc == '0) ? eff_w : r_pl;
    assign ovr_base = (r_bc == '0) ? 1'b0 : r_ovr;
    assign bc_inc   = (r_bc != srle_pkg::BYTE_SAT) ? r_bc + 1'b1 : r_bc;

    // next repeat group: min(GROUP, run left, pixels left)
    always_comb begin
        grp_n = 3'(srle_pkg::GROUP);
        if ({4'b0, grp_n} > r_run) begin
            grp_n = r_run[2:0];
        end
        if (srle_pkg::PL_W'(grp_n) > r_pl) begin
            grp_n = r_pl[2:0];
        end
    end

    assign rem_run  = r_run - 7'(grp_n);
    assign rem_pl   = r_pl - srle_pkg::PL_W'(grp_n);
    assign grp_last = (rem_run == '0) || (rem_pl == '0);

    assign o_stat.out_free     = out_free;
    assign o_stat.phase_repeat = (r_phase == srle_pkg::PH_REPEAT);
    assign o_stat.group_last   = grp_last;

    always_comb begin
        n_phase     = r_phase;
        n_run       = r_run;
        n_pl        = r_pl;
        n_bc        = r_bc;
        n_ovr       = r_ovr;
        n_rep_val   = r_rep_val;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.take_byte) begin
            n_pl  = pl_base;
            n_ovr = ovr_base;
            n_bc  = bc_inc;
            case (r_phase)
                srle_pkg::PH_LITERAL: begin
                    if (pl_base != '0) begin
                        n_pl = pl_base - 1'b1;
                    end else begin
                        n_ovr = 1'b1;   // byte past the width is dropped
                    end
                    if (r_run != '0) begin
                        n_run = r_run - 1'b1;
                    end
                    if (n_run == '0) begin
                        n_phase = srle_pkg::PH_HEADER;
                    end
                    if ((pl_base != '0) || ((n_run == '0) && (n_pl == '0))) begin
                        n_out_valid   = 1'b1;
                        n_out         = '0;
                        n_out.pixel[0] = (pl_base != '0) ? i_byte : 8'd0;
                        n_out.count   = (pl_base != '0) ? 3'd1 : 3'd0;
                        if ((n_run == '0) && (n_pl == '0)) begin
                            n_out.row_end   = 1'b1;
                            n_out.status    = n_ovr ? srle_pkg::RS_OVERRUN
                                                    : srle_pkg::RS_DONE;
                            n_out.row_bytes = bc_inc;
                            n_phase = srle_pkg::PH_HEADER;
                            n_run   = '0;
                            n_bc    = '0;
                            n_ovr   = 1'b0;
                        end
                    end
                end
                srle_pkg::PH_REPEAT: begin
                    n_rep_val = i_byte;
                end
                default: begin
                    if (i_byte[6:0] == '0) begin
                        // terminator
                        n_out_valid     = 1'b1;
                        n_out           = '0;
                        n_out.row_end   = 1'b1;
                        n_out.status    = (pl_base != '0) ? srle_pkg::RS_SHORT :
                                          ovr_base ? srle_pkg::RS_OVERRUN :
                                                     srle_pkg::RS_DONE;
                        n_out.row_bytes = bc_inc;
                        n_phase = srle_pkg::PH_HEADER;
                        n_run   = '0;
                        n_bc    = '0;
                        n_ovr   = 1'b0;
                    end else begin
                        n_run   = i_byte[6:0];
                        n_phase = i_byte[7] ? srle_pkg::PH_LITERAL : srle_pkg::PH_REPEAT;
                    end
                end
            endcase
        end else if (i_cmd.emit_group) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            for (int j = 0; j < 4; j++) begin
                n_out.pixel[j] = (3'(j) < grp_n) ? r_rep_val : 8'd0;
            end
            n_out.count = grp_n;
            n_run       = rem_run;
            n_pl        = rem_pl;
            if (grp_last) begin
                n_phase = srle_pkg::PH_HEADER;
                n_run   = '0;
            end
            if (rem_pl == '0) begin
                // width filled: leftover run length means clipped overrun
                n_out.row_end   = 1'b1;
                n_out.status    = (r_ovr || (rem_run != '0)) ? srle_pkg::RS_OVERRUN
                                                            : srle_pkg::RS_DONE;
                n_out.row_bytes = r_bc;
                n_bc  = '0;
                n_ovr = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= srle_pkg::WIDTH_RESET;
            r_phase     <= srle_pkg::PH_HEADER;
            r_run       <= '0;
            r_pl        <= '0;
            r_bc        <= '0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_row_width <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_pl        <= n_pl;
            r_bc        <= n_bc;
            r_ovr       <= n_ovr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_val <= n_rep_val;
        r_out     <= n_out;
    end

    assign o_result    = r_out;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_cmd_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_byte || i_cmd.emit_group) |-> out_free)
        else $error("command issued while output slot is occupied");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take_byte && i_cmd.emit_group))
        else $error("byte intake and group emit in the same cycle");

    a_end_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.row_end) |-> (r_out.status != srle_pkg::RS_BUSY))
        else $error("row end without a final status");

    a_mid_row_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.row_end) |->
            ((r_out.status == srle_pkg::RS_BUSY) && (r_out.row_bytes == '0)
             && (r_out.count != 3'd0)))
        else $error("mid-row result carries end fields or no pixels");
`endif

endmodule

// ===== hw/rtl/sgi_rle8_row_decoder.sv =====
// Top level of the 8-bit RLE scanline decoder.
// Depends on srle_pkg, srle_ctrl and srle_dpath.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[7:0] data_byte
//  m_axis    out  tvalid/tready           tdata pixels/count/row_bytes, tuser status,
//                                         tlast row_end
//  cfg       in   i_cfg_wr_en (no wait)   i_cfg_wr_data row_width
//
// Header and literal bytes are taken straight from s_axis; a repeat value byte is then
// emitted in 4-pixel groups, ceil(min(count, pixels left) / 4) of them.
// The single output register sets the pace: one result per cycle at most.
// Reset is synchronous; row_width returns to 512 and the row state clears.
// A stalled m_axis holds the result and blocks both intake and group emit.
module sgi_rle8_row_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [srle_pkg::WIDTH_W-1:0] i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] pixel_a, [15:8] pixel_b, [23:16] pixel_c, [31:24] pixel_d,
    // [34:32] pixel_count, [49:35] row_bytes, [55:50] zero
    output logic [55:0]                  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,   // [1:0] status
    output logic                         m_axis_tlast    // row_end
);

    srle_pkg::t_cmd    cmd;
    srle_pkg::t_stat   stat;
    srle_pkg::t_result res;

    srle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srle_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (res),
        .o_out_valid   (m_axis_tvalid)
    );

    assign m_axis_tdata = {6'b0, res.row_bytes, res.count,
                           res.pixel[3], res.pixel[2], res.pixel[1], res.pixel[0]};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.row_end;

endmodule
